@@ sv/ray_pixel_traversal_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ray pixel traversal unit
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RAY_PIXEL_TRAVERSAL_UNIT_MACROS_SVH
`define RAY_PIXEL_TRAVERSAL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RPTU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset
`define RPTU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/rptu_pkg.sv @@
// ----------------------------------------------------------------------------
// rptu_pkg
// Types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rptu_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int MAX_RESULTS   = 63;
  // grid position width in Q.30 for grids up to 32 pixels
  localparam int GW            = 35;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  // 10000 * d <= 2^30  <=>  d <= 107374
  localparam logic [GW-1:0] ALIGN_D_MAX = GW'(107374);

  typedef struct packed {
    logic signed [15:0] dir_cos;
    logic signed [15:0] dir_sin;
    logic signed [15:0] offset;
  } rptu_in_t;

  typedef struct packed {
    logic [4:0]  cell_col;
    logic [4:0]  cell_row;
    logic [15:0] seg_weight;
    logic        last;
  } rptu_out_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic sqrt_step;
    logic hmul;
    logic twice;
    logic gpos;
    logic axis;
    logic div_start;
    logic div_sel_next;
    logic cap_step;
    logic cap_next;
    logic walk;
  } rptu_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_last;
  } rptu_sts_t;

endpackage

@@ sv/rptu_div.sv @@
// ----------------------------------------------------------------------------
// rptu_div
// Restoring divider, one quotient bit per cycle, 32-bit saturating quotient.
// ----------------------------------------------------------------------------
module rptu_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [60:0]             num,
  input  logic [rptu_pkg::GW-1:0] den,
  output logic                    done,
  output logic [31:0]             quo
);

  localparam int W = rptu_pkg::GW;

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] den_r;
  logic [31:0]  lo_r, q_r;
  logic [5:0]   cnt_r;
  logic         busy_r, done_r, sat_r;
  logic [W:0]   trial;
  logic         qbit;

  always_comb begin
    trial = {rem_r, lo_r[31]};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= W'(num[60:32]);
      lo_r  <= num[31:0];
      den_r <= den;
      sat_r <= (W'(num[60:32]) >= den);
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = sat_r ? 32'hFFFF_FFFF : q_r;

endmodule

@@ sv/rptu_ctrl.sv @@
// ----------------------------------------------------------------------------
// rptu_ctrl
// Sequencer: setup steps, square root, divisions, then the pixel walk.
// ----------------------------------------------------------------------------
module rptu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rptu_pkg::rptu_sts_t  sts,
  output rptu_pkg::rptu_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ      = 4'd1;
  localparam logic [3:0] S_SQRT    = 4'd2;
  localparam logic [3:0] S_HMUL    = 4'd3;
  localparam logic [3:0] S_TWICE   = 4'd4;
  localparam logic [3:0] S_GPOS    = 4'd5;
  localparam logic [3:0] S_AXIS    = 4'd6;
  localparam logic [3:0] S_DS_GO   = 4'd7;
  localparam logic [3:0] S_DS_WAIT = 4'd8;
  localparam logic [3:0] S_DN_GO   = 4'd9;
  localparam logic [3:0] S_DN_WAIT = 4'd10;
  localparam logic [3:0] S_WALK    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_HMUL;
        end
      end
      S_HMUL: begin
        cmd.hmul  = 1'b1;
        state_nxt = S_TWICE;
      end
      S_TWICE: begin
        cmd.twice = 1'b1;
        state_nxt = S_GPOS;
      end
      S_GPOS: begin
        cmd.gpos  = 1'b1;
        state_nxt = S_AXIS;
      end
      S_AXIS: begin
        cmd.axis  = 1'b1;
        state_nxt = S_DS_GO;
      end
      S_DS_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DS_WAIT;
      end
      S_DS_WAIT: begin
        cmd.cap_step = sts.div_done;
        if (sts.div_done) begin
          state_nxt = S_DN_GO;
        end
      end
      S_DN_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_next = 1'b1;
        state_nxt        = S_DN_WAIT;
      end
      S_DN_WAIT: begin
        cmd.cap_next = sts.div_done;
        if (sts.div_done) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/rptu_dp.sv @@
// ----------------------------------------------------------------------------
// rptu_dp
// Datapath: chord setup, per-axis divisions, pixel walk and output register.
// ----------------------------------------------------------------------------
module rptu_dp #(
  parameter int GRID_SIZE = rptu_pkg::GRID_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rptu_pkg::rptu_cmd_t cmd,
  output rptu_pkg::rptu_sts_t sts,
  input  rptu_pkg::rptu_in_t  in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output rptu_pkg::rptu_out_t out_data
);

  localparam int W = rptu_pkg::GW;
  localparam logic [W-1:0] G_LIM = W'((64'(GRID_SIZE) << 30) - 64'd1);
  localparam logic [31:0]  ONE   = rptu_pkg::Q30_ONE;
  localparam logic [5:0]   K_FIN = 6'(rptu_pkg::MAX_RESULTS - 1);

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    sx34 = {{2{v[31]}}, v};
  endfunction

  function automatic logic [W-1:0] grid_pos(input logic signed [33:0] tw);
    logic [39:0] p;
    logic [38:0] g;
    p = 40'(tw[32:0]) * 40'(GRID_SIZE);
    g = p[39:1];
    if (tw <= 34'sd0) begin
      grid_pos = '0;
    end else if (g > 39'(G_LIM)) begin
      grid_pos = G_LIM;
    end else begin
      grid_pos = g[W-1:0];
    end
  endfunction

  // setup registers
  logic signed [15:0] c_r, sn_r, s_r;
  logic signed [31:0] px_r, py_r, hx_r, hy_r;
  logic [30:0]        v_r, res_r, bit_r;
  logic signed [33:0] tw_r [4];
  logic [W-1:0]       g_r [4];
  logic [W-1:0]       dc_r, dr_r;
  logic [30:0]        nnc_r, nnr_r;
  logic               alc_r, alr_r;

  // walk state
  logic [5:0]  cur_col_r, cur_row_r, end_col_r, end_row_r, k_r;
  logic [31:0] ncc_r, ncr_r, stc_r, str_r, t_r;
  logic [15:0] chord_r;
  logic [1:0]  signs_r;

  // output register
  logic                out_valid_r;
  rptu_pkg::rptu_out_t out_r, item;

  // square root step
  logic [31:0] rb_sum;
  logic        rb_ge;
  assign rb_sum = 32'(res_r) + 32'(bit_r);
  assign rb_ge  = ({1'b0, v_r} >= rb_sum);

  // multipliers
  logic signed [31:0] ss_prod, sc_prod, ssn_prod;
  logic signed [32:0] hsn_prod, hc_prod;
  assign ss_prod  = s_r * s_r;
  assign sc_prod  = s_r * c_r;
  assign ssn_prod = s_r * sn_r;
  assign hsn_prod = $signed({1'b0, res_r[15:0]}) * sn_r;
  assign hc_prod  = $signed({1'b0, res_r[15:0]}) * c_r;

  // axis setup
  logic         dn_c, dn_r;
  logic [W-1:0] dc, dr;
  assign dn_c = g_r[1] < g_r[0];
  assign dn_r = g_r[3] < g_r[2];
  assign dc   = dn_c ? g_r[0] - g_r[1] : g_r[1] - g_r[0];
  assign dr   = dn_r ? g_r[2] - g_r[3] : g_r[3] - g_r[2];

  // dividers
  logic [60:0] num_c, num_r;
  logic [31:0] q_c, q_r;
  logic        done_c, done_r;
  assign num_c = cmd.div_sel_next ? {nnc_r, 30'd0} : 61'(1) << 60;
  assign num_r = cmd.div_sel_next ? {nnr_r, 30'd0} : 61'(1) << 60;

  rptu_div u_div_col (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_c), .den(dc_r), .done(done_c), .quo(q_c)
  );

  rptu_div u_div_row (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_r), .den(dr_r), .done(done_r), .quo(q_r)
  );

  // walk step
  logic        ca, ra, fin, take_col, slot_free, push;
  logic [31:0] tn0, tn1, tn, t1, dt;
  logic [47:0] wprod;
  logic [17:0] wq;
  logic [32:0] ncc_sum, ncr_sum;

  always_comb begin
    ca       = cur_col_r != end_col_r;
    ra       = cur_row_r != end_row_r;
    fin      = (!ca && !ra) || (k_r >= K_FIN);
    take_col = ca && (!ra || (ncc_r < ncr_r));
    tn0      = take_col ? ncc_r : ncr_r;
    tn1      = (tn0 < t_r) ? t_r : tn0;
    tn       = (tn1 > ONE) ? ONE : tn1;
    t1       = fin ? ONE : tn;
    dt       = (t1 > t_r) ? t1 - t_r : 32'd0;
    wprod    = 48'(dt) * 48'(chord_r);
    wq       = wprod[47:30];
    ncc_sum  = {1'b0, ncc_r} + {1'b0, stc_r};
    ncr_sum  = {1'b0, ncr_r} + {1'b0, str_r};
    item.cell_col   = cur_col_r[4:0];
    item.cell_row   = cur_row_r[4:0];
    item.seg_weight = (wq > 18'hFFFF) ? 16'hFFFF : wq[15:0];
    item.last       = fin;
  end

  assign slot_free     = !out_valid_r || out_ready;
  assign push          = cmd.walk && slot_free;
  assign sts.div_done  = done_c && done_r;
  assign sts.walk_last = push && fin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r  <= in_data.dir_cos;
      sn_r <= in_data.dir_sin;
      s_r  <= in_data.offset;
    end
    if (cmd.sq) begin
      v_r   <= 31'(32'sh4000_0000 - ss_prod);
      res_r <= '0;
      bit_r <= 31'(ONE);
      px_r  <= sc_prod;
      py_r  <= ssn_prod;
    end
    if (cmd.sqrt_step) begin
      if (rb_ge) begin
        v_r   <= 31'(32'(v_r) - rb_sum);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.hmul) begin
      chord_r <= res_r[15:0];
      hx_r    <= 32'(-hsn_prod);
      hy_r    <= 32'(hc_prod);
    end
    if (cmd.twice) begin
      tw_r[0] <= sx34(px_r) + sx34(hx_r) + 34'(ONE);
      tw_r[1] <= sx34(px_r) - sx34(hx_r) + 34'(ONE);
      tw_r[2] <= sx34(py_r) + sx34(hy_r) + 34'(ONE);
      tw_r[3] <= sx34(py_r) - sx34(hy_r) + 34'(ONE);
    end
    if (cmd.gpos) begin
      for (int i = 0; i < 4; i++) begin
        g_r[i] <= grid_pos(tw_r[i]);
      end
    end
    if (cmd.axis) begin
      dc_r  <= dc;
      dr_r  <= dr;
      alc_r <= dc <= rptu_pkg::ALIGN_D_MAX;
      alr_r <= dr <= rptu_pkg::ALIGN_D_MAX;
      nnc_r <= dn_c ? {1'b0, g_r[0][29:0]} : 31'(ONE) - {1'b0, g_r[0][29:0]};
      nnr_r <= dn_r ? {1'b0, g_r[2][29:0]} : 31'(ONE) - {1'b0, g_r[2][29:0]};
    end
    if (push) begin
      out_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      end_col_r   <= '0;
      end_row_r   <= '0;
      ncc_r       <= '0;
      ncr_r       <= '0;
      stc_r       <= '0;
      str_r       <= '0;
      t_r         <= '0;
      signs_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.axis) begin
        cur_col_r <= {1'b0, g_r[0][W-1:30]};
        cur_row_r <= {1'b0, g_r[2][W-1:30]};
        end_col_r <= (dc <= rptu_pkg::ALIGN_D_MAX) ? {1'b0, g_r[0][W-1:30]}
                                                   : {1'b0, g_r[1][W-1:30]};
        end_row_r <= (dr <= rptu_pkg::ALIGN_D_MAX) ? {1'b0, g_r[2][W-1:30]}
                                                   : {1'b0, g_r[3][W-1:30]};
        signs_r   <= {dn_r, dn_c};
        t_r       <= '0;
        k_r       <= '0;
      end
      if (cmd.cap_step) begin
        stc_r <= alc_r ? 32'd0 : q_c;
        str_r <= alr_r ? 32'd0 : q_r;
      end
      if (cmd.cap_next) begin
        ncc_r <= alc_r ? 32'd0 : q_c;
        ncr_r <= alr_r ? 32'd0 : q_r;
      end
      // advance the walk on every pixel that is not the final one
      if (push && !fin) begin
        if (take_col) begin
          cur_col_r <= signs_r[0] ? cur_col_r - 6'd1 : cur_col_r + 6'd1;
          ncc_r     <= ncc_sum[32] ? 32'hFFFF_FFFF : ncc_sum[31:0];
        end else begin
          cur_row_r <= signs_r[1] ? cur_row_r - 6'd1 : cur_row_r + 6'd1;
          ncr_r     <= ncr_sum[32] ? 32'hFFFF_FFFF : ncr_sum[31:0];
        end
        t_r <= tn;
        k_r <= k_r + 6'd1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sv/ray_pixel_traversal_unit.sv @@
// ----------------------------------------------------------------------------
// ray_pixel_traversal_unit
// Walks the pixels that a ray crosses in an N x N grid, one weight per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one ray per transfer (direction cosine and sine, signed offset,
//            all Q1.15). in_ready is high only while the unit is idle.
//   out_*  : one transfer per crossed pixel: column, row, chord length inside
//            the pixel in Q1.15, and last on the final pixel of the ray.
//            A ray gives 1 to 63 results.
//   Sequence: from the input transfer to the first result being offered:
//            1 squaring, 16 square-root steps, 4 setup steps, two divisions
//            (step, then first crossing; each a start state and a wait
//            state) on one restoring divider per axis, both axes at once,
//            then the result is registered into the output register.
//   Throughput: one pixel per cycle during the walk while out_ready is high;
//            a new ray is taken only in the idle state after the previous
//            ray's final pixel; the divisions dominate the setup.
//   Stall: results sit in a single output register; while a result waits
//            and out_ready is low the walk holds and nothing is dropped.
//   Reset: rst_n (synchronous, active low) returns the sequencer to idle and
//            empties the output register.
// ----------------------------------------------------------------------------
module ray_pixel_traversal_unit #(
  parameter int GRID_SIZE = rptu_pkg::GRID_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rptu_pkg::rptu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rptu_pkg::rptu_out_t out_data
);

  rptu_pkg::rptu_cmd_t cmd;
  rptu_pkg::rptu_sts_t sts;

  // sequencer: steps the setup and the walk
  rptu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, walk state and output register
  rptu_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sv/rptu_chk.sv @@
// ----------------------------------------------------------------------------
// rptu_chk
// Port-level checks on the ray pixel traversal unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_pixel_traversal_unit_macros.svh"

module rptu_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rptu_pkg::rptu_out_t out_data
);

  // a stalled result holds
  `RPTU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // a ray occupies the unit: no second transfer straight after one
  `RPTU_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready held after input transfer")

  // a new ray only starts once the previous ray's final pixel is out
  `RPTU_ASSERT_NOW(a_in_after_last, in_valid && in_ready, !out_valid || out_data.last, "input taken mid-ray")

endmodule

bind ray_pixel_traversal_unit rptu_chk u_rptu_chk (.*);
